// ===== design/tun_pkg.sv =====
// Shared widths for the triangle unit normal pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none
package tun_pkg;
  localparam int SCALED_W = 31;
  localparam int SUM_W    = 64;
  localparam int LEN_W    = 32;
  localparam int OUT_W    = 32;
endpackage
`default_nettype wire

// ===== design/tun_isqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Depends on tun_pkg for the radicand and root widths.
`default_nettype none
module tun_isqrt
  import tun_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [SUM_W-1:0]  rad,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   out_valid,
  output logic [LEN_W-1:0]       root,
  output logic [SIDE_W-1:0]      side_out
);
  localparam int NS = LEN_W;

  logic               vld  [0:NS];
  logic [LEN_W+1:0]   rem  [0:NS];
  logic [LEN_W-1:0]   rt   [0:NS];
  logic [SUM_W-1:0]   rd   [0:NS];
  logic [SIDE_W-1:0]  sd   [0:NS];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign rd[0]  = rad;
  assign sd[0]  = side_in;

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic [LEN_W+1:0] cur;
    logic [LEN_W+1:0] trial;
    logic             ge;
    logic [LEN_W+1:0] rem_next;

    always_comb begin
      cur      = {rem[j][LEN_W-1:0], rd[j][SUM_W-1 -: 2]};
      trial    = {rt[j], 2'b01};
      ge       = cur >= trial;
      rem_next = ge ? cur - trial : cur;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      rem[j+1] <= rem_next;
      rt[j+1]  <= {rt[j][LEN_W-2:0], ge};
      rd[j+1]  <= {rd[j][SUM_W-3:0], 2'b00};
      sd[j+1]  <= sd[j];
    end
  end

  assign out_valid = vld[NS];
  assign root      = rt[NS];
  assign side_out  = sd[NS];
endmodule
`default_nettype wire

// ===== design/tun_div3.sv =====
// Three-lane pipelined restoring divider with a shared divisor and rounding.
// Depends on tun_pkg for the scaled component and length widths.
`default_nettype none
module tun_div3
  import tun_pkg::*;
#(
  parameter int FRAC   = 30,
  parameter int SIDE_W = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [2:0][SCALED_W-1:0]      num,
  input  wire logic [LEN_W-1:0]              len,
  input  wire logic [SIDE_W-1:0]             side_in,
  output logic                               out_valid,
  output logic [2:0][FRAC+1:0]               quo,
  output logic [SIDE_W-1:0]                  side_out
);
  localparam int NW = SCALED_W + FRAC + 1;
  localparam int QW = FRAC + 2;

  logic                     vld [0:QW];
  logic [2:0][LEN_W-1:0]    rem [0:QW];
  logic [2:0][QW-1:0]       bts [0:QW];
  logic [2:0][QW-1:0]       q   [0:QW];
  logic [LEN_W-1:0]         dv  [0:QW];
  logic [SIDE_W-1:0]        sd  [0:QW];

  always_comb begin
    logic [NW-1:0] n;
    for (int k = 0; k < 3; k++) begin
      n = {1'b0, num[k], {FRAC{1'b0}}} + NW'(len >> 1);
      rem[0][k] = LEN_W'(n[NW-1:QW]);
      bts[0][k] = n[QW-1:0];
      q[0][k]   = '0;
    end
  end
  assign vld[0] = in_valid;
  assign dv[0]  = len;
  assign sd[0]  = side_in;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [2:0][LEN_W-1:0] rem_next;
    logic [2:0]            ge;

    always_comb begin
      logic [LEN_W:0] cur;
      logic [LEN_W:0] diff;
      for (int k = 0; k < 3; k++) begin
        cur         = {rem[j][k], bts[j][k][QW-1-j]};
        diff        = cur - {1'b0, dv[j]};
        ge[k]       = cur >= {1'b0, dv[j]};
        rem_next[k] = ge[k] ? diff[LEN_W-1:0] : cur[LEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      rem[j+1] <= rem_next;
      bts[j+1] <= bts[j];
      for (int k = 0; k < 3; k++) begin
        q[j+1][k] <= {q[j][k][QW-2:0], ge[k]};
      end
      dv[j+1]  <= dv[j];
      sd[j+1]  <= sd[j];
    end
  end

  assign out_valid = vld[QW];
  assign quo       = q[QW];
  assign side_out  = sd[QW];
endmodule
`default_nettype wire

// ===== design/triangle_unit_normal_top.sv =====
// Unit face normal of a triangle: edges, cross product, scaling, length, division.
// Depends on tun_pkg, tun_isqrt and tun_div3.
// The pipeline has eight arithmetic stages, 32 square-root stages,
// NORMAL_FRAC_BITS+2 divider stages and the output register.
// Throughput is one triangle per cycle; busy is never raised and the receiver cannot stall.
// Synchronous reset clears every valid bit; data registers are not reset.
`default_nettype none
module triangle_unit_normal_top
  import tun_pkg::*;
#(
  parameter int COORD_WIDTH      = 32,
  parameter int NORMAL_FRAC_BITS = 30
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [31:0]       ax,
  input  wire logic [31:0]       ay,
  input  wire logic [31:0]       az,
  input  wire logic [31:0]       bx,
  input  wire logic [31:0]       by,
  input  wire logic [31:0]       bz,
  input  wire logic [31:0]       cx,
  input  wire logic [31:0]       cy,
  input  wire logic [31:0]       cz,
  output logic                   done,
  output logic [OUT_W-1:0]       nx,
  output logic [OUT_W-1:0]       ny,
  output logic [OUT_W-1:0]       nz,
  output logic                   degenerate
);
  localparam int CW = COORD_WIDTH;
  localparam int EW = CW + 1;
  localparam int PW = 2 * EW;
  localparam int XW = PW + 1;
  localparam int LW = $clog2(XW + 1);
  localparam int QW = NORMAL_FRAC_BITS + 2;
  localparam int SIDE_W = 3 * SCALED_W + 4;
  localparam int SQ_W = 2 * SCALED_W;

  logic [CW-1:0] av [3];
  logic [CW-1:0] bv [3];
  logic [CW-1:0] cv [3];

  assign av[0] = ax[CW-1:0];
  assign av[1] = ay[CW-1:0];
  assign av[2] = az[CW-1:0];
  assign bv[0] = bx[CW-1:0];
  assign bv[1] = by[CW-1:0];
  assign bv[2] = bz[CW-1:0];
  assign cv[0] = cx[CW-1:0];
  assign cv[1] = cy[CW-1:0];
  assign cv[2] = cz[CW-1:0];

  assign busy = 1'b0;

  logic                 v1, v2, v3, v4, v5, v6, v7, v8;
  logic signed [EW-1:0] d [3];
  logic signed [EW-1:0] e [3];
  logic signed [PW-1:0] p [6];
  logic        [XW-1:0] x [3];
  logic        [XW-1:0] m4 [3];
  logic        [XW-1:0] m5 [3];
  logic [2:0]           neg4, neg5, neg6, neg7, neg8;
  logic                 deg4, deg5, deg6, deg7, deg8;
  logic [LW-1:0]        ml;
  logic [LW-1:0]        ml_next;
  logic [2:0][SCALED_W-1:0] s6, s7, s8;
  logic [2*SCALED_W-1:0]    sq [3];
  logic [SUM_W-1:0]         sum;
  logic [XW+SCALED_W-1:0]   sh [3];

  always_comb begin
    ml_next = '0;
    for (int i = 0; i < XW; i++) begin
      if ((m4[0][i] | m4[1][i] | m4[2][i]) == 1'b1) begin
        ml_next = LW'(i + 1);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sh[k] = {m5[k], {SCALED_W{1'b0}}} >> ml;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
    for (int k = 0; k < 3; k++) begin
      d[k] <= {av[k][CW-1], av[k]} - {bv[k][CW-1], bv[k]};
      e[k] <= {cv[k][CW-1], cv[k]} - {bv[k][CW-1], bv[k]};
    end
    p[0] <= PW'(d[1]) * PW'(e[2]);
    p[1] <= PW'(e[1]) * PW'(d[2]);
    p[2] <= PW'(e[0]) * PW'(d[2]);
    p[3] <= PW'(d[0]) * PW'(e[2]);
    p[4] <= PW'(d[0]) * PW'(e[1]);
    p[5] <= PW'(e[0]) * PW'(d[1]);
    for (int k = 0; k < 3; k++) begin
      x[k] <= {p[2*k][PW-1], p[2*k]} - {p[2*k+1][PW-1], p[2*k+1]};
    end
    for (int k = 0; k < 3; k++) begin
      neg4[k] <= x[k][XW-1];
      m4[k]   <= x[k][XW-1] ? -x[k] : x[k];
    end
    deg4 <= (x[0] == '0) && (x[1] == '0) && (x[2] == '0);
    m5   <= m4;
    neg5 <= neg4;
    deg5 <= deg4;
    ml   <= ml_next;
    for (int k = 0; k < 3; k++) begin
      s6[k] <= sh[k][SCALED_W-1:0];
    end
    neg6 <= neg5;
    deg6 <= deg5;
    for (int k = 0; k < 3; k++) begin
      sq[k] <= SQ_W'(s6[k]) * SQ_W'(s6[k]);
    end
    s7   <= s6;
    neg7 <= neg6;
    deg7 <= deg6;
    sum  <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    s8   <= s7;
    neg8 <= neg7;
    deg8 <= deg7;
  end

  logic                 sq_valid;
  logic [LEN_W-1:0]     len;
  logic [SIDE_W-1:0]    sq_side;

  tun_isqrt #(
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v8),
    .rad       (sum),
    .side_in   ({s8, neg8, deg8}),
    .out_valid (sq_valid),
    .root      (len),
    .side_out  (sq_side)
  );

  logic               dv_valid;
  logic [2:0][QW-1:0] quo;
  logic [3:0]         dv_side;

  tun_div3 #(
    .FRAC   (NORMAL_FRAC_BITS),
    .SIDE_W (4)
  ) u_div3 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .num       (sq_side[SIDE_W-1:4]),
    .len       (len),
    .side_in   (sq_side[3:0]),
    .out_valid (dv_valid),
    .quo       (quo),
    .side_out  (dv_side)
  );

  logic [OUT_W-1:0] comp [3];

  always_comb begin
    logic [OUT_W-1:0] mag;
    for (int k = 0; k < 3; k++) begin
      mag = OUT_W'(quo[k]);
      if (dv_side[0]) begin
        comp[k] = '0;
      end else if (dv_side[1+k]) begin
        comp[k] = -mag;
      end else begin
        comp[k] = mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
    nx         <= comp[0];
    ny         <= comp[1];
    nz         <= comp[2];
    degenerate <= dv_side[0];
  end
endmodule
`default_nettype wire

// ===== verif/triangle_unit_normal_top_tb.sv =====
// Testbench for triangle_unit_normal_top: directed table then random triangles.
// Depends on the block and tun_pkg; results are checked in order vs table or predictor.
`default_nettype none
module triangle_unit_normal_top_tb
  import tun_pkg::*;
();

  localparam int NFRAC = 30;
  localparam int NRAND = 1300;

  typedef logic [8:0][31:0] tri_t;
  typedef struct packed {
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
    logic        deg;
  } normal_t;
  typedef struct packed {
    tri_t    verts;
    logic    typed;
    normal_t want;
  } row_t;

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] MONE = 32'hFFFF_0000;
  localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NMAX = 32'h8000_0000;
  localparam logic [31:0] UNIT = 32'h4000_0000;
  localparam logic [31:0] MUNIT = 32'hC000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [31:0] ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
  logic [31:0] cx = '0, cy = '0, cz = '0;
  logic done;
  logic [OUT_W-1:0] nx, ny, nz;
  logic degenerate;

  logic    req_typed = 1'b0;
  normal_t req_want = '0;
  normal_t normals_due[$];
  int      mismatches = 0;

  triangle_unit_normal_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
    .cx(cx), .cy(cy), .cz(cz),
    .done(done), .nx(nx), .ny(ny), .nz(nz), .degenerate(degenerate)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res, b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic normal_t unit_normal(input tri_t t);
    logic signed [33:0] d[3], e[3];
    logic signed [67:0] c[3];
    logic [67:0] m[3];
    logic        neg[3];
    logic [63:0] s[3], sum, len, q, v;
    int top, bl;
    normal_t r;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed(t[i]) - $signed(t[3 + i]);
      e[i] = $signed(t[6 + i]) - $signed(t[3 + i]);
    end
    c[0] = d[1] * e[2] - e[1] * d[2];
    c[1] = e[0] * d[2] - d[0] * e[2];
    c[2] = d[0] * e[1] - e[0] * d[1];
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i][67];
      m[i] = neg[i] ? -c[i] : c[i];
      bl = 0;
      for (int k = 0; k < 68; k++) if (m[i][k]) bl = k + 1;
      if (bl > top) top = bl;
    end
    r = '0;
    if (top == 0) begin
      r.deg = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      if (top > 31) s[i] = 64'(m[i] >> (top - 31));
      else s[i] = 64'(m[i] << (31 - top));
    end
    sum = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
    len = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((s[i] << NFRAC) + (len >> 1)) / len;
      v = neg[i] ? -q : q;
      if (i == 0) r.nx = v[31:0];
      else if (i == 1) r.ny = v[31:0];
      else r.nz = v[31:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    normal_t want, got;
    if (!rst && done) begin
      got = '{nx: nx, ny: ny, nz: nz, deg: degenerate};
      if (normals_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h %h %h %b", nx, ny, nz, degenerate);
      end else begin
        want = normals_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h %h %h %b, got %h %h %h %b",
                     want.nx, want.ny, want.nz, want.deg, nx, ny, nz, degenerate);
        end
      end
    end
    if (!rst && start && !busy)
      normals_due.insert(normals_due.size(), req_typed ? req_want
                         : unit_normal({cz, cy, cx, bz, by, bx, az, ay, ax}));
  end

  function automatic logic [31:0] rand_coord(input int scale);
    logic [31:0] v;
    v = $urandom;
    if (scale < 31) v = 32'($signed(v << (31 - scale)) >>> (31 - scale));
    return v;
  endfunction

  function automatic tri_t rand_triangle();
    tri_t t;
    int scale, kind, p, q;
    kind = $urandom_range(0, 19);
    scale = ($urandom_range(0, 3) == 0) ? 31 : $urandom_range(0, 31);
    for (int i = 0; i < 9; i++) t[i] = rand_coord(scale);
    if (kind == 0) begin
      t[8:6] = t[2:0];
    end else if (kind == 1) begin
      t[5:3] = t[8:6];
    end else if (kind == 2) begin
      p = $urandom_range(0, 7) - 3;
      q = $urandom_range(0, 7) - 3;
      for (int i = 0; i < 3; i++) begin
        t[3 + i] = 32'($signed(t[i]) >>> 4);
        t[i] = 32'($signed(t[3 + i]) + p * ($signed(t[i]) >>> 8));
        t[6 + i] = 32'($signed(t[3 + i]) + q * ($signed(t[i] - t[3 + i])));
      end
    end else if (kind == 3) begin
      for (int i = 0; i < 9; i++) t[i] = $urandom_range(0, 1) ? PMAX : NMAX;
    end
    return t;
  endfunction

  task automatic send(input tri_t t, input logic typed, input normal_t want);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    {cz, cy, cx, bz, by, bx, az, ay, ax} <= t;
    req_typed <= typed;
    req_want <= want;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  row_t rows[$];

  initial begin
    rows = '{
      '{'0, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b1}},
      '{{MONE, ONE, ONE, MONE, ONE, ONE, ONE, ONE, ONE}, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b1}},
      '{{32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, ONE}, 1'b1,
        '{32'd0, 32'd0, 32'd0, 1'b1}},
      '{{32'd0, ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, ONE}, 1'b1,
        '{32'd0, 32'd0, UNIT, 1'b0}},
      '{{32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 32'd0, ONE, 32'd0}, 1'b1,
        '{32'd0, 32'd0, MUNIT, 1'b0}},
      '{{ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, ONE, 32'd0}, 1'b1,
        '{UNIT, 32'd0, 32'd0, 1'b0}},
      '{{32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0}, 1'b1,
        '{32'd0, UNIT, 32'd0, 1'b0}},
      '{{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX}, 1'b1,
        '{32'd0, 32'd0, 32'd0, 1'b1}},
      '{{NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX}, 1'b1,
        '{32'd0, 32'd0, 32'd0, 1'b1}},
      '{{NMAX, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, PMAX, 32'd0}, 1'b0, '0},
      '{{NMAX, PMAX, NMAX, PMAX, NMAX, PMAX, NMAX, PMAX, NMAX}, 1'b0, '0},
      '{{PMAX, NMAX, 32'd0, NMAX, PMAX, NMAX, 32'd0, NMAX, PMAX}, 1'b0, '0},
      '{{32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0}, 1'b0, '0},
      '{{32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0}, 1'b0, '0},
      '{{32'd3, 32'd1, 32'd2, 32'd0, 32'd0, 32'd0, 32'd1, 32'd2, 32'd3}, 1'b0, '0},
      '{{PMAX, PMAX, NMAX, NMAX, NMAX, PMAX, PMAX, NMAX, PMAX}, 1'b0, '0},
      '{{32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0},
        1'b0, '0},
      '{{32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 32'h5555_5555, 32'hAAAA_AAAA,
         32'h3333_3333, 32'hCCCC_CCCC, 32'h7777_7777, 32'h8888_8888}, 1'b0, '0}
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send(rows[i].verts, rows[i].typed, rows[i].want);
    for (int n = 0; n < NRAND; n++) begin
      if (n == NRAND / 2) begin
        start <= 1'b0;
        while (normals_due.size() != 0) @(posedge clk);
      end
      send(rand_triangle(), 1'b0, '0);
    end
    start <= 1'b0;
    while (normals_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #(12 * 300000);
    $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
